/* rtl/core/astd_pkg.sv */
// ----------------------------------------------------------------------------
// astd_pkg
// Shared widths, types and helpers for the shake and tilt detector core.
// ----------------------------------------------------------------------------
package astd_pkg;

  // sample and result widths
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned OP_W     = AXIS_W + 1;
  localparam int unsigned PROD_W   = 2 * OP_W;
  localparam int unsigned ROOT_W   = 17;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned SEED_W   = 32;
  localparam int unsigned HSQ_W    = 32;
  localparam int unsigned YSQ_W    = 31;

  // fixed point of the samples and seed scaling
  localparam int unsigned ACCEL_FRAC_BITS = 12;
  localparam logic [OP_W-1:0] SEED_SCALE  = OP_W'(1000);

  // register reset values and indexes
  localparam logic [LEVEL_W-1:0] ON_LEVEL_RST  = LEVEL_W'(2048);
  localparam logic [LEVEL_W-1:0] OFF_LEVEL_RST = LEVEL_W'(1229);
  localparam logic               REG_ON_LEVEL  = 1'b0;
  localparam logic               REG_OFF_LEVEL = 1'b1;

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  // magnitude of a 17-bit signed value
  function automatic logic [OP_W-1:0] abs_op(input logic signed [OP_W-1:0] v);
    logic [OP_W-1:0] r;
    r = v[OP_W-1] ? OP_W'(-v) : OP_W'(v);
    return r;
  endfunction

endpackage

/* rtl/core/astd_mul.sv */
// ----------------------------------------------------------------------------
// astd_mul
// Shared 17x17 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module astd_mul
  import astd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [OP_W-1:0]   op_a,
  input  logic [OP_W-1:0]   op_b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  // product holds while the unit is not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/core/astd_isqrt.sv */
// ----------------------------------------------------------------------------
// astd_isqrt
// Digit-by-digit floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module astd_isqrt
  import astd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output sqrt_stat_t        stat
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // one root bit per step
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      cnt_nxt = cnt_r - 1'b1;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* rtl/core/accel_shake_tilt_detector_core.sv */
// ----------------------------------------------------------------------------
// accel_shake_tilt_detector_core
// Shake detection with hysteresis, tilt classification and seed sum for
// three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// One sample word gives one result word. The squaring steps feed six
// squarings, one after the other, through a single 17x17 multiplier. The
// 34-bit floor square root then runs 17 steps in its own unit. The seed
// state scales the root through the same multiplier, and the final state
// loads the output register. The input is ready only while the core is
// idle, which is in the cycle after the output register is loaded, so a new
// sample is taken only once the previous one has passed the final step. A
// finished result waits in the output register, so the next sample can be
// taken before it is read; that sample's final step waits as long as the
// previous result is still unread. Threshold registers are to be written
// only while the core is idle; the core itself does not enforce this.
module accel_shake_tilt_detector_core
  import astd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // config write port
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_wdata,
  // sample stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // accel_x, accel_y, accel_z
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // motion_magnitude, filtered_magnitude,
                                   // shaking, shake_start, tilted_down,
                                   // tilted_up, motion_sum, zero pad
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_SEED = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // squaring steps
  localparam logic [2:0] STEP_DX  = 3'd0;
  localparam logic [2:0] STEP_DY  = 3'd1;
  localparam logic [2:0] STEP_DZ  = 3'd2;
  localparam logic [2:0] STEP_LX  = 3'd3;
  localparam logic [2:0] STEP_LZ  = 3'd4;
  localparam logic [2:0] STEP_LY  = 3'd5;
  localparam logic [2:0] STEP_END = 3'd6;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  logic [LEVEL_W-1:0] on_level_r, off_level_r;
  logic signed [AXIS_W-1:0] x_r, y_r, z_r;
  logic signed [AXIS_W-1:0] last_x_r, last_y_r, last_z_r;
  logic [LEVEL_W-1:0] level_r;
  logic               shake_r;
  logic [SEED_W-1:0]  seed_r;
  logic [RAD_W-1:0]   sum_r;
  logic [HSQ_W-1:0]   hsq_r;
  logic [YSQ_W-1:0]   ysq_r;
  logic               out_valid_r;
  logic [71:0]        out_data_r;

  logic              in_acc;
  logic              fin_go;
  logic              mul_en;
  logic [OP_W-1:0]   op_a, op_b, sq_op;
  logic [PROD_W-1:0] prod;
  logic              sqrt_start;
  logic [ROOT_W-1:0] mag;
  sqrt_stat_t        sq_stat;

  logic [LEVEL_W:0]   level_sum;
  logic [LEVEL_W-1:0] level_nxt;
  logic               shake_nxt;
  logic               vert, down, up;
  logic [SEED_W-1:0]  seed_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // operand for the current squaring step
  always_comb begin
    case (cnt_r)
      STEP_DX: sq_op = abs_op(OP_W'(x_r) - OP_W'(last_x_r));
      STEP_DY: sq_op = abs_op(OP_W'(y_r) - OP_W'(last_y_r));
      STEP_DZ: sq_op = abs_op(OP_W'(z_r) - OP_W'(last_z_r));
      STEP_LX: sq_op = abs_op(OP_W'(last_x_r));
      STEP_LZ: sq_op = abs_op(OP_W'(last_z_r));
      STEP_LY: sq_op = abs_op(OP_W'(last_y_r));
      default: sq_op = '0;
    endcase
  end

  // shared multiplier feed
  always_comb begin
    mul_en = 1'b0;
    op_a   = sq_op;
    op_b   = sq_op;
    if (state_r == ST_SQ && cnt_r != STEP_END) begin
      mul_en = 1'b1;
    end else if (state_r == ST_SEED) begin
      mul_en = 1'b1;
      op_a   = OP_W'(mag);
      op_b   = SEED_SCALE;
    end
  end

  astd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign sqrt_start = (state_r == ST_SQ) && (cnt_r == STEP_END);

  astd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .root     (mag),
    .stat     (sq_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_END) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_stat.done) state_nxt = ST_SEED;
      end
      ST_SEED: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_level_r  <= ON_LEVEL_RST;
      off_level_r <= OFF_LEVEL_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_ON_LEVEL)  on_level_r  <= cfg_wdata;
      if (cfg_index == REG_OFF_LEVEL) off_level_r <= cfg_wdata;
    end
  end

  // sample capture and product accumulation
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_tdata[15:0];
      y_r   <= in_tdata[31:16];
      z_r   <= in_tdata[47:32];
      sum_r <= '0;
      hsq_r <= '0;
    end else if (state_r == ST_SQ) begin
      case (cnt_r)
        STEP_DY, STEP_DZ, STEP_LX: sum_r <= sum_r + prod;
        STEP_LZ, STEP_LY:          hsq_r <= hsq_r + prod[HSQ_W-1:0];
        STEP_END:                  ysq_r <= prod[YSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // filter, hysteresis, tilt of the previous sample and seed for the finished sample
  always_comb begin
    level_sum = {1'b0, level_r} + {1'b0, mag};
    level_nxt = level_sum[LEVEL_W:1];
    shake_nxt = shake_r;
    if (shake_r) begin
      if (level_nxt < off_level_r) shake_nxt = 1'b0;
    end else begin
      if (level_nxt > on_level_r) shake_nxt = 1'b1;
    end
    vert     = HSQ_W'(ysq_r) > hsq_r;
    down     = vert && last_y_r[AXIS_W-1];
    up       = vert && !last_y_r[AXIS_W-1];
    seed_nxt = seed_r + SEED_W'(prod >> ACCEL_FRAC_BITS);
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= '0;
      last_y_r <= '0;
      last_z_r <= '0;
      level_r  <= '0;
      shake_r  <= 1'b0;
      seed_r   <= '0;
    end else if (fin_go) begin
      last_x_r <= x_r;
      last_y_r <= y_r;
      last_z_r <= z_r;
      level_r  <= level_nxt;
      shake_r  <= shake_nxt;
      seed_r   <= seed_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= {2'b00, seed_nxt, up, down, shake_nxt && !shake_r,
                     shake_nxt, level_nxt, mag};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a sample is taken only from idle, so the core is busy right after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready one cycle after a sample was accepted");

  // the root finishes only while the sequencer waits for it
  a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> state_r == ST_ROOT)
    else $error("square root finished outside the root state");

  // the root unit iterates only inside the root state
  a_root_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.busy |-> state_r == ST_ROOT)
    else $error("square root busy outside the root state");

  // a new result shows up only after the final step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FIN))
    else $error("result word raised without a final step");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the shake and tilt detector core. Sample words are
// queued by the stimulus process and sent by a clocked driver. Each accepted
// word runs through a local model of the detector, and the predicted result
// is checked field by field against the result stream. Gaps on both sides,
// a long receiver hold-off and several threshold settings are covered.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import astd_pkg::*;

  // one sample word, accel_x in the lowest bits
  typedef struct packed {
    logic signed [AXIS_W-1:0] z;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] x;
  } sample_t;

  // one result word as the detector reports it
  typedef struct {
    logic [ROOT_W-1:0]  mag;
    logic [LEVEL_W-1:0] level;
    logic               shaking;
    logic               start;
    logic               down;
    logic               up;
    logic [SEED_W-1:0]  seed;
  } report_t;

  localparam int ACCEL_G = 4096;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  sample_t pending_samples[$];
  report_t predicted_reports[$];

  // detector model state
  logic signed [AXIS_W-1:0] prev_x, prev_y, prev_z;
  logic [LEVEL_W-1:0]       lpf_level;
  logic                     shake_state;
  logic [SEED_W-1:0]        seed_acc;
  logic [LEVEL_W-1:0]       on_level;
  logic [LEVEL_W-1:0]       off_level;

  int  n_errors = 0;
  int  n_results = 0;
  int  n_samples = 0;
  int  n_starts = 0;
  int  n_tilt_up = 0;
  int  n_tilt_down = 0;
  int  n_cfg = 0;
  bit  steady_in = 1'b0;
  bit  steady_out = 1'b0;
  logic hold_go = 1'b0;
  int  hold_cnt;
  int  in_gap;
  int  out_gap;

  accel_shake_tilt_detector_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor square root, one result bit per pass from the top
  function automatic logic [ROOT_W-1:0] floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[ROOT_W-1:0];
  endfunction

  // step the detector model with one sample, return its result word
  function automatic report_t advance_detector(input sample_t s);
    report_t r;
    longint dx, dy, dz, ysq, hsq;
    logic [LEVEL_W:0] level_sum;
    logic             was_shaking;
    dx = longint'(s.x) - longint'(prev_x);
    dy = longint'(s.y) - longint'(prev_y);
    dz = longint'(s.z) - longint'(prev_z);
    r.mag = floor_root(longint'(dx * dx + dy * dy + dz * dz));
    // tilt is judged on the previous sample
    ysq = longint'(prev_y) * longint'(prev_y);
    hsq = longint'(prev_x) * longint'(prev_x) + longint'(prev_z) * longint'(prev_z);
    r.down = (ysq > hsq) && (prev_y < 0);
    r.up   = (ysq > hsq) && (prev_y > 0);
    prev_x = s.x;
    prev_y = s.y;
    prev_z = s.z;
    seed_acc = seed_acc + SEED_W'((longint'(r.mag) * 1000) >>> ACCEL_FRAC_BITS);
    level_sum = {1'b0, lpf_level} + {1'b0, r.mag};
    lpf_level = level_sum[LEVEL_W:1];
    // hysteresis, equal to a level means no change
    was_shaking = shake_state;
    if (shake_state) begin
      if (lpf_level < off_level) shake_state = 1'b0;
    end else begin
      if (lpf_level > on_level) shake_state = 1'b1;
    end
    r.level   = lpf_level;
    r.shaking = shake_state;
    r.start   = shake_state && !was_shaking;
    r.seed    = seed_acc;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [AXIS_W-1:0] clamp_axis(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return AXIS_W'(v);
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
             $realtime, what, n_results, got, want);
    n_errors++;
  endtask

  // sample driver
  always @(posedge clk) begin
    sample_t s;
    report_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        r = advance_detector(sample_t'(in_tdata));
        predicted_reports.push_back(r);
        n_samples++;
        n_starts    += r.start;
        n_tilt_up   += r.up;
        n_tilt_down += r.down;
      end
      if (in_tvalid && !in_tready) begin
        // word still on offer
      end else if (in_gap != 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        s = pending_samples.pop_front();
        in_tdata  <= s;
        in_tvalid <= 1'b1;
        in_gap    <= steady_in ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_go) begin
      hold_cnt <= 400;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result monitor and ready control
  always @(posedge clk) begin
    report_t got, want;
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.mag     = out_tdata[16:0];
        got.level   = out_tdata[33:17];
        got.shaking = out_tdata[34];
        got.start   = out_tdata[35];
        got.down    = out_tdata[36];
        got.up      = out_tdata[37];
        got.seed    = out_tdata[69:38];
        if (predicted_reports.size() == 0) begin
          flag_mismatch("unexpected word", got.mag, -1);
        end else begin
          want = predicted_reports.pop_front();
          if (got.mag !== want.mag) flag_mismatch("motion_magnitude", got.mag, want.mag);
          if (got.level !== want.level)
            flag_mismatch("filtered_magnitude", got.level, want.level);
          if (got.shaking !== want.shaking)
            flag_mismatch("shaking", got.shaking, want.shaking);
          if (got.start !== want.start)
            flag_mismatch("shake_start", got.start, want.start);
          if (got.down !== want.down) flag_mismatch("tilted_down", got.down, want.down);
          if (got.up !== want.up) flag_mismatch("tilted_up", got.up, want.up);
          if (got.seed !== want.seed) flag_mismatch("motion_sum", got.seed, want.seed);
        end
        n_results++;
      end
      if (hold_cnt > 1) begin
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        g = steady_out ? 0 : pick_gap();
        out_gap    <= g;
        out_tready <= (g == 0);
      end else if (out_gap != 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= (out_gap == 1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // register write, only while the core is idle
  task automatic write_level(input logic idx, input logic [LEVEL_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_ON_LEVEL) on_level = val;
    else off_level = val;
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_levels(input logic [LEVEL_W-1:0] on_v, input logic [LEVEL_W-1:0] off_v);
    write_level(REG_ON_LEVEL, on_v);
    write_level(REG_OFF_LEVEL, off_v);
  endtask

  // wait until every queued sample has been answered
  task automatic drain();
    int n;
    n = 0;
    @(negedge clk);
    while ((pending_samples.size() != 0 || in_tvalid || predicted_reports.size() != 0)
           && n < 50000) begin
      @(negedge clk);
      n++;
    end
    if (predicted_reports.size() != 0) begin
      $display("[%0t] %0d results never arrived", $realtime, predicted_reports.size());
      n_errors++;
      predicted_reports.delete();
    end
    repeat (40) @(negedge clk);
  endtask

  task automatic queue_sample(input int x, input int y, input int z);
    sample_t s;
    s.x = clamp_axis(x);
    s.y = clamp_axis(y);
    s.z = clamp_axis(z);
    pending_samples.push_back(s);
  endtask

  // a run of calm or shaking motion around one orientation
  task automatic queue_motion(input int len);
    int bx, by, bz, amp, orient, sgn;
    bit shake;
    sample_t s;
    orient = $urandom_range(0, 4);
    bx = 0;
    by = 0;
    bz = 0;
    case (orient)
      0: by = ACCEL_G;
      1: by = -ACCEL_G;
      2: bx = ACCEL_G;
      3: bz = -ACCEL_G;
      default: begin
        bx = int'($urandom_range(0, 24000)) - 12000;
        by = int'($urandom_range(0, 24000)) - 12000;
        bz = int'($urandom_range(0, 24000)) - 12000;
      end
    endcase
    shake = 1'($urandom_range(0, 1));
    amp = shake ? $urandom_range(1500, 24000) : $urandom_range(0, 400);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        // raw noise word
        s = sample_t'(48'({$urandom, $urandom}));
        pending_samples.push_back(s);
      end else if (shake) begin
        sgn = i[0] ? 1 : -1;
        queue_sample(bx + sgn * int'($urandom_range(amp / 2, amp)),
                     by - sgn * int'($urandom_range(amp / 2, amp)),
                     bz + sgn * int'($urandom_range(amp / 2, amp)));
      end else begin
        queue_sample(bx + int'($urandom_range(0, 2 * amp)) - amp,
                     by + int'($urandom_range(0, 2 * amp)) - amp,
                     bz + int'($urandom_range(0, 2 * amp)) - amp);
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    int target;
    logic [LEVEL_W-1:0] on_v, off_v;
    prev_x      = '0;
    prev_y      = '0;
    prev_z      = '0;
    lpf_level   = '0;
    shake_state = 1'b0;
    seed_acc    = '0;
    on_level    = ON_LEVEL_RST;
    off_level   = OFF_LEVEL_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // level lands exactly on a threshold, first sample has no tilt
    set_levels(17'd4096, 17'd4096);
    queue_sample(8192, 0, 0);
    queue_sample(16384, 0, 0);
    queue_sample(18432, 0, 0);
    queue_sample(18432, 0, 0);
    drain();

    // field extremes and tilt cases at the reset levels
    set_levels(ON_LEVEL_RST, OFF_LEVEL_RST);
    queue_sample(32767, 32767, 32767);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(0, 32767, 0);
    queue_sample(0, -32768, 0);
    queue_sample(0, ACCEL_G, 0);
    queue_sample(3, 5, 4);
    queue_sample(0, 0, 0);
    queue_sample(-1, -1, -1);
    queue_sample(ACCEL_G, 0, ACCEL_G);
    queue_sample(0, -ACCEL_G, 0);
    queue_sample(-32768, 0, 32767);
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 0);
    drain();

    // random motion under several threshold settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin on_v = ON_LEVEL_RST; off_v = OFF_LEVEL_RST; end
        1: begin on_v = '0; off_v = '0; end
        2: begin on_v = '1; off_v = '1; end
        3: begin on_v = 17'd500; off_v = 17'd3000; end
        4: begin on_v = '1; off_v = '0; end
        default: begin
          on_v  = LEVEL_W'($urandom_range(1000, 20000));
          off_v = LEVEL_W'($urandom_range(0, on_v));
        end
      endcase
      set_levels(on_v, off_v);
      steady_in  = (p == 4);
      steady_out = (p == 4);
      target = pending_samples.size() + 45;
      while (pending_samples.size() < target) queue_motion($urandom_range(5, 25));
      if (p == 5) begin
        // receiver stops while samples keep coming
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      drain();
    end

    $display("run covered %0d samples and %0d results over %0d register writes",
             n_samples, n_results, n_cfg);
    $display("shake starts %0d, tilt up %0d, tilt down %0d",
             n_starts, n_tilt_up, n_tilt_down);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("[%0t] run timed out", $realtime);
    $display("Verification failed");
    $finish;
  end

endmodule
